FILE: src/hdft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill decrypt package
// Shared types, letter codes and the mod-26 reduction used by the datapath.
// ----------------------------------------------------------------------------
package hdft_pkg;

    localparam int LETTER_W = 5;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [LETTER_W-1:0] LET_E = 5'd4;
    localparam logic [LETTER_W-1:0] LET_T = 5'd19;
    localparam logic [LETTER_W-1:0] LET_X = 5'd23;
    localparam logic [LETTER_W-1:0] LET_Z = 5'd25;

    // Register indexes taken from paddr[3:2].
    localparam logic [1:0] REG_K00 = 2'd0;
    localparam logic [1:0] REG_K01 = 2'd1;
    localparam logic [1:0] REG_K10 = 2'd2;
    localparam logic [1:0] REG_K11 = 2'd3;

    typedef struct packed {
        logic [LETTER_W-1:0] k00;
        logic [LETTER_W-1:0] k01;
        logic [LETTER_W-1:0] k10;
        logic [LETTER_W-1:0] k11;
    } t_key;

    typedef struct packed {
        logic [LETTER_W-1:0] plain_first;
        logic [LETTER_W-1:0] plain_second;
        logic                last_pair;
        logic [1:0]          hit_t;
        logic [1:0]          hit_e;
        logic [1:0]          hit_z;
        logic [1:0]          hit_x;
    } t_letter_req;

    // Reduces a sum of two 5x5 products (at most 1922) modulo 26.
    // The quotient comes from a multiply by 2521/65536, which is exact below 2048.
    function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] x);
        logic [22:0] prod;
        logic [6:0]  quo;
        logic [10:0] rem;
        prod = {12'd0, x} * 23'd2521;
        quo  = prod[22:16];
        rem  = x - 11'({4'd0, quo} * 11'd26);
        return rem[LETTER_W-1:0];
    endfunction

    function automatic logic [1:0] hits(input logic [LETTER_W-1:0] a,
                                        input logic [LETTER_W-1:0] b,
                                        input logic [LETTER_W-1:0] letter);
        return {1'b0, (a == letter)} + {1'b0, (b == letter)};
    endfunction

endpackage

FILE: src/hdft_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill decrypt channels
// Valid/ready channels for ciphertext pairs and decrypted results.
// ----------------------------------------------------------------------------
interface hdft_pair_if;
    logic       valid;
    logic       ready;
    logic [4:0] cipher_first;
    logic [4:0] cipher_second;
    logic       last_pair;

    modport source (output valid, output cipher_first, output cipher_second,
                    output last_pair, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second,
                    input last_pair, output ready);
endinterface

interface hdft_plain_if;
    logic       valid;
    logic       ready;
    logic [4:0] plain_first;
    logic [4:0] plain_second;
    logic       verdict_valid;
    logic       looks_english;

    modport source (output valid, output plain_first, output plain_second,
                    output verdict_valid, output looks_english, input ready);
    modport sink   (input valid, input plain_first, input plain_second,
                    input verdict_valid, input looks_english, output ready);
endinterface

FILE: src/hdft_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill decrypt key registers
// APB-style register file holding the four 2x2 key matrix entries.
// ----------------------------------------------------------------------------
module hdft_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hdft_pkg::ADDR_W-1:0] paddr,
    input  logic [hdft_pkg::DATA_W-1:0] pwdata,
    output logic [hdft_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output hdft_pkg::t_key              o_key
);
    import hdft_pkg::*;

    t_key                r_key;
    logic                wr_en;
    logic [1:0]          reg_idx;
    logic [LETTER_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.k00 <= 5'd1;
            r_key.k01 <= 5'd0;
            r_key.k10 <= 5'd0;
            r_key.k11 <= 5'd1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_K00: r_key.k00 <= pwdata[LETTER_W-1:0];
                REG_K01: r_key.k01 <= pwdata[LETTER_W-1:0];
                REG_K10: r_key.k10 <= pwdata[LETTER_W-1:0];
                REG_K11: r_key.k11 <= pwdata[LETTER_W-1:0];
                default: r_key <= r_key;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_K00: rd_val = r_key.k00;
            REG_K01: rd_val = r_key.k01;
            REG_K10: rd_val = r_key.k10;
            REG_K11: rd_val = r_key.k11;
            default: rd_val = '0;
        endcase
    end

    assign prdata = {{(DATA_W-LETTER_W){1'b0}}, rd_val};
    assign o_key  = r_key;

`ifndef NO_ASSERTIONS
    property p_write_lands;
        @(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && reg_idx == REG_K00) |=> (r_key.k00 == $past(pwdata[LETTER_W-1:0]));
    endproperty
    a_write_lands: assert property (p_write_lands)
        else $error("key entry not updated by write");
`endif

endmodule

FILE: src/hdft_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill decrypt matrix stage
// Registers the ciphertext pair, multiplies it by the key mod 26 and flags
// the letters that the frequency test counts.
// ----------------------------------------------------------------------------
module hdft_mix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hdft_pkg::t_key        i_key,
    hdft_pair_if.sink             i_pair,
    output hdft_pkg::t_letter_req o_req,
    output logic                  o_req_valid,
    input  logic                  i_req_ready
);
    import hdft_pkg::*;

    logic                r_s1_valid;
    logic [LETTER_W-1:0] r_p;
    logic [LETTER_W-1:0] r_q;
    logic                r_last;
    logic                r_s2_valid;
    t_letter_req         r_s2;
    t_letter_req         n_s2;
    logic                s1_ready;
    logic                s2_ready;
    logic [10:0]         sum_first;
    logic [10:0]         sum_second;

    assign s2_ready     = !r_s2_valid || i_req_ready;
    assign s1_ready     = !r_s1_valid || s2_ready;
    assign i_pair.ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_pair.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_pair.valid) begin
            r_p    <= i_pair.cipher_first;
            r_q    <= i_pair.cipher_second;
            r_last <= i_pair.last_pair;
        end
    end

    // Row vector [p q] times the key matrix.
    always_comb begin
        sum_first  = 11'({5'd0, r_p} * {5'd0, i_key.k00}) +
                     11'({5'd0, r_q} * {5'd0, i_key.k10});
        sum_second = 11'({5'd0, r_p} * {5'd0, i_key.k01}) +
                     11'({5'd0, r_q} * {5'd0, i_key.k11});
        n_s2.plain_first  = mod26(sum_first);
        n_s2.plain_second = mod26(sum_second);
        n_s2.last_pair    = r_last;
        n_s2.hit_t = hits(n_s2.plain_first, n_s2.plain_second, LET_T);
        n_s2.hit_e = hits(n_s2.plain_first, n_s2.plain_second, LET_E);
        n_s2.hit_z = hits(n_s2.plain_first, n_s2.plain_second, LET_Z);
        n_s2.hit_x = hits(n_s2.plain_first, n_s2.plain_second, LET_X);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_req       = r_s2;
    assign o_req_valid = r_s2_valid;

`ifndef NO_ASSERTIONS
    property p_letters_in_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2.plain_first < 5'd26 && r_s2.plain_second < 5'd26);
    endproperty
    a_letters_in_range: assert property (p_letters_in_range)
        else $error("decrypted letter out of range");

    property p_stalled_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !i_req_ready) |=> (r_s2_valid && $stable(r_s2));
    endproperty
    a_stalled_hold: assert property (p_stalled_hold)
        else $error("letter stage changed while stalled");
`endif

endmodule

FILE: src/hdft_freq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill decrypt frequency test
// Saturating letter counters, the English verdict on the last pair and the
// result register.
// ----------------------------------------------------------------------------
module hdft_freq #(
    parameter int MAX_LETTERS = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hdft_pkg::t_letter_req i_req,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    hdft_plain_if.source          o_plain
);
    import hdft_pkg::*;

    localparam int CW = $clog2(MAX_LETTERS + 1);
    localparam int PW = CW + 7;
    localparam logic [CW:0] MAX_V = (CW+1)'(MAX_LETTERS);

    logic [CW-1:0]       r_cnt_t;
    logic [CW-1:0]       r_cnt_e;
    logic [CW-1:0]       r_cnt_z;
    logic [CW-1:0]       r_cnt_x;
    logic [CW-1:0]       r_total;
    logic [CW-1:0]       n_cnt_t;
    logic [CW-1:0]       n_cnt_e;
    logic [CW-1:0]       n_cnt_z;
    logic [CW-1:0]       n_cnt_x;
    logic [CW-1:0]       n_total;
    logic                r_valid;
    logic [LETTER_W-1:0] r_plain_first;
    logic [LETTER_W-1:0] r_plain_second;
    logic                r_verdict_valid;
    logic                r_looks_english;
    logic                take;
    logic                english;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c,
                                              input logic [1:0] inc);
        logic [CW:0] s;
        s = {1'b0, c} + (CW+1)'(inc);
        if (s > MAX_V) begin
            s = MAX_V;
        end
        return s[CW-1:0];
    endfunction

    assign o_req_ready = !r_valid || o_plain.ready;
    assign take        = i_req_valid && o_req_ready;

    always_comb begin
        n_cnt_t = sat_add(r_cnt_t, i_req.hit_t);
        n_cnt_e = sat_add(r_cnt_e, i_req.hit_e);
        n_cnt_z = sat_add(r_cnt_z, i_req.hit_z);
        n_cnt_x = sat_add(r_cnt_x, i_req.hit_x);
        n_total = sat_add(r_total, 2'd2);
        // Percent thresholds as exact cross-multiplication against the total.
        english = (PW'(n_cnt_t) * PW'(100) > PW'(n_total) * PW'(6)) &&
                  (PW'(n_cnt_e) * PW'(100) > PW'(n_total) * PW'(8)) &&
                  (PW'(n_cnt_z) * PW'(100) < PW'(n_total) * PW'(2)) &&
                  (PW'(n_cnt_x) * PW'(100) < PW'(n_total) * PW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_t <= '0;
            r_cnt_e <= '0;
            r_cnt_z <= '0;
            r_cnt_x <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_req.last_pair) begin
                    r_cnt_t <= '0;
                    r_cnt_e <= '0;
                    r_cnt_z <= '0;
                    r_cnt_x <= '0;
                    r_total <= '0;
                end else begin
                    r_cnt_t <= n_cnt_t;
                    r_cnt_e <= n_cnt_e;
                    r_cnt_z <= n_cnt_z;
                    r_cnt_x <= n_cnt_x;
                    r_total <= n_total;
                end
            end
            if (o_req_ready) begin
                r_valid <= i_req_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_plain_first   <= i_req.plain_first;
            r_plain_second  <= i_req.plain_second;
            r_verdict_valid <= i_req.last_pair;
            r_looks_english <= i_req.last_pair && english;
        end
    end

    assign o_plain.valid         = r_valid;
    assign o_plain.plain_first   = r_plain_first;
    assign o_plain.plain_second  = r_plain_second;
    assign o_plain.verdict_valid = r_verdict_valid;
    assign o_plain.looks_english = r_looks_english;

`ifndef NO_ASSERTIONS
    property p_verdict_gated;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (!r_looks_english || r_verdict_valid);
    endproperty
    a_verdict_gated: assert property (p_verdict_gated)
        else $error("verdict raised on a pair that is not last");

    property p_clear_after_last;
        @(posedge i_clk) disable iff (!i_rst_n)
        (take && i_req.last_pair) |=> (r_total == '0 && r_cnt_t == '0);
    endproperty
    a_clear_after_last: assert property (p_clear_after_last)
        else $error("counters not cleared after the last pair");

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_total} <= MAX_V) && (r_cnt_t <= r_total) && (r_cnt_e <= r_total);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("letter counter beyond limit or above total");
`endif

endmodule

FILE: src/hill_decrypt_with_frequency_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill decrypt with frequency test
// 2x2 Hill cipher decryption mod 26 with an English letter-frequency verdict
// given on the last pair of each message.
// ----------------------------------------------------------------------------
//  channel   direction  kind        contents
//  i_pair    in         valid/ready cipher_first, cipher_second, last_pair
//  o_plain   out        valid/ready plain_first, plain_second, verdict_valid,
//                                   looks_english
//  APB       in/out     psel/penable four 5-bit key entries at 0x0..0xC
//
// One request is accepted every cycle unless a stalled output has filled the
// pipeline; each result passes through every stage below before o_plain shows it.
// The depth is set by the input register, the matrix/mod-26 stage and the
// counter/verdict stage with its result register.
// Reset loads the identity key and clears all counters and valid flags.
// Each stage holds its request while the next stage is full, so a stalled
// output fills the pipeline before the input ready falls.
// ----------------------------------------------------------------------------
module hill_decrypt_with_frequency_test_unit #(
    parameter int MAX_LETTERS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hdft_pair_if.sink                   i_pair,
    hdft_plain_if.source                o_plain,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hdft_pkg::ADDR_W-1:0] paddr,
    input  logic [hdft_pkg::DATA_W-1:0] pwdata,
    output logic [hdft_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import hdft_pkg::*;

    t_key        key;
    t_letter_req req;
    logic        req_valid;
    logic        req_ready;

    hdft_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (key)
    );

    hdft_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key),
        .i_pair      (i_pair),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready)
    );

    hdft_freq #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_freq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .o_plain     (o_plain)
    );

endmodule

FILE: verif/hdft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill decrypt checker
// Watches the pair and plain channels and the key register port. It keeps its
// own key and letter counters, works out the decrypted pair and verdict for
// every accepted request, and compares each accepted result against the
// oldest one still pending.
// ----------------------------------------------------------------------------
module hdft_checker #(
    parameter int MAX_LETTERS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hdft_pair_if                        i_pair,
    hdft_plain_if                       i_plain,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hdft_pkg::ADDR_W-1:0] paddr,
    input  logic [hdft_pkg::DATA_W-1:0] pwdata,
    input  logic                        pready,
    output int                          o_fail_count,
    output int                          o_pending
);
    import hdft_pkg::*;

    localparam int CNT_W = $clog2(MAX_LETTERS + 1);

    typedef struct packed {
        logic [LETTER_W-1:0] plain_first;
        logic [LETTER_W-1:0] plain_second;
        logic                verdict_valid;
        logic                looks_english;
    } t_plain_result;

    t_plain_result    plain_q[$];
    t_key             key;
    logic [CNT_W-1:0] cnt_t;
    logic [CNT_W-1:0] cnt_e;
    logic [CNT_W-1:0] cnt_z;
    logic [CNT_W-1:0] cnt_x;
    logic [CNT_W-1:0] cnt_total;
    int               fail_count = 0;
    int unsigned      results_seen = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("checker: result %0d: %s", results_seen, msg);
        fail_count++;
    endtask

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] c,
                                                  input int unsigned inc);
        int unsigned sum;
        sum = c + inc;
        return (sum > MAX_LETTERS) ? CNT_W'(MAX_LETTERS) : CNT_W'(sum);
    endfunction

    function automatic int unsigned letter_hits(input int unsigned f, input int unsigned s,
                                                input logic [LETTER_W-1:0] letter);
        return int'(f == letter) + int'(s == letter);
    endfunction

    // Decrypts one pair with the current key and advances the letter counts.
    function automatic t_plain_result decrypt_pair(input logic [LETTER_W-1:0] c1,
                                                   input logic [LETTER_W-1:0] c2,
                                                   input logic last);
        int unsigned   a;
        int unsigned   b;
        int unsigned   f;
        int unsigned   s;
        int unsigned   tot;
        t_plain_result r;
        a = c1;
        b = c2;
        f = (a * key.k00 + b * key.k10) % 26;
        s = (a * key.k01 + b * key.k11) % 26;
        cnt_t     = sat_bump(cnt_t, letter_hits(f, s, LET_T));
        cnt_e     = sat_bump(cnt_e, letter_hits(f, s, LET_E));
        cnt_z     = sat_bump(cnt_z, letter_hits(f, s, LET_Z));
        cnt_x     = sat_bump(cnt_x, letter_hits(f, s, LET_X));
        cnt_total = sat_bump(cnt_total, 2);
        tot = cnt_total;
        r.plain_first   = LETTER_W'(f);
        r.plain_second  = LETTER_W'(s);
        r.verdict_valid = last;
        r.looks_english = last && (100 * cnt_t > 6 * tot) && (100 * cnt_e > 8 * tot) &&
                          (100 * cnt_z < 2 * tot) && (100 * cnt_x < 2 * tot);
        if (last) begin
            cnt_t     = '0;
            cnt_e     = '0;
            cnt_z     = '0;
            cnt_x     = '0;
            cnt_total = '0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_plain_result got;
        t_plain_result want;
        if (!i_rst_n) begin
            plain_q.delete();
            key       = '{k00: 5'd1, k01: 5'd0, k10: 5'd0, k11: 5'd1};
            cnt_t     = '0;
            cnt_e     = '0;
            cnt_z     = '0;
            cnt_x     = '0;
            cnt_total = '0;
        end else begin
            if (i_plain.valid && i_plain.ready) begin
                got = '{plain_first: i_plain.plain_first, plain_second: i_plain.plain_second,
                        verdict_valid: i_plain.verdict_valid,
                        looks_english: i_plain.looks_english};
                if (plain_q.size() == 0) begin
                    report_mismatch($sformatf("result %p with nothing pending", got));
                end else begin
                    want = plain_q.pop_front();
                    if (got.plain_first !== want.plain_first)
                        report_mismatch($sformatf("plain_first got %0d, expected %0d",
                                                  got.plain_first, want.plain_first));
                    if (got.plain_second !== want.plain_second)
                        report_mismatch($sformatf("plain_second got %0d, expected %0d",
                                                  got.plain_second, want.plain_second));
                    if (got.verdict_valid !== want.verdict_valid)
                        report_mismatch($sformatf("verdict_valid got %b, expected %b",
                                                  got.verdict_valid, want.verdict_valid));
                    if (got.looks_english !== want.looks_english)
                        report_mismatch($sformatf("looks_english got %b, expected %b",
                                                  got.looks_english, want.looks_english));
                end
                results_seen++;
            end
            if (i_pair.valid && i_pair.ready) begin
                plain_q.push_back(decrypt_pair(i_pair.cipher_first, i_pair.cipher_second,
                                               i_pair.last_pair));
            end
            // Key writes land after the pair of this edge, which used the old key.
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_K00: key.k00 = pwdata[LETTER_W-1:0];
                    REG_K01: key.k01 = pwdata[LETTER_W-1:0];
                    REG_K10: key.k10 = pwdata[LETTER_W-1:0];
                    REG_K11: key.k11 = pwdata[LETTER_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= plain_q.size();
    end

endmodule

FILE: verif/hill_decrypt_with_frequency_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hill decrypt with frequency test bench
// Drives ciphertext pairs and key writes into the unit, stalls both channels
// at random and leaves the prediction and comparison to the checker. Covers
// extreme keys and letters, a long stream with no idling and random messages
// that are mostly built from English-like plaintext.
// ----------------------------------------------------------------------------
module hill_decrypt_with_frequency_test_unit_tb;
    import hdft_pkg::*;

    localparam int MAX_LETTERS  = 4096;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_PAIRS = 280;
    localparam int PHASE_PAIRS  = 50;
    localparam int STREAM_PAIRS = 40;
    localparam int TAIL_CYCLES  = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending_results;
    int unsigned       cycle_count = 0;
    int unsigned       tx_idle_pct = 18;
    int unsigned       rx_idle_pct = 18;
    t_key              cur_key;

    hdft_pair_if  pair_ch ();
    hdft_plain_if plain_ch ();

    hill_decrypt_with_frequency_test_unit #(
        .MAX_LETTERS(MAX_LETTERS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_ch),
        .o_plain (plain_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hdft_checker #(
        .MAX_LETTERS(MAX_LETTERS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair       (pair_ch),
        .i_plain      (plain_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            plain_ch.ready <= 1'b0;
        end else begin
            plain_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_pair(input logic [4:0] c1, input logic [4:0] c2, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            pair_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_ch.valid         <= 1'b1;
        pair_ch.cipher_first  <= c1;
        pair_ch.cipher_second <= c2;
        pair_ch.last_pair     <= last;
        do @(posedge i_clk); while (!pair_ch.ready);
    endtask

    task automatic send_run(input logic [4:0] c1, input logic [4:0] c2, input int n,
                            input logic last);
        for (int i = 0; i < n; i++) begin
            send_pair(c1, c2, last && (i == n - 1));
        end
    endtask

    // The sender goes idle first. The pending count is registered, so look at it
    // only after the next edge.
    task automatic drain();
        pair_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [4:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {27'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_key(input logic [4:0] k00, input logic [4:0] k01,
                           input logic [4:0] k10, input logic [4:0] k11);
        write_key(REG_K00, k00);
        write_key(REG_K01, k01);
        write_key(REG_K10, k10);
        write_key(REG_K11, k11);
        cur_key = '{k00: k00, k01: k01, k10: k10, k11: k11};
    endtask

    // Plaintext letters skewed toward English: plenty of T and E, Z and X at a
    // chosen rate, the rest drawn from A..W.
    function automatic logic [4:0] pick_plain(input int unsigned zx_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return LET_T;
        if (r < 24) return LET_E;
        if (r < 24 + zx_pct) return LET_Z;
        if (r < 24 + 2 * zx_pct) return LET_X;
        return 5'($urandom_range(22));
    endfunction

    // Finds a ciphertext pair that the key turns into the wanted plaintext.
    function automatic bit find_cipher(input t_key k, input logic [4:0] f,
                                       input logic [4:0] s,
                                       output logic [4:0] c1, output logic [4:0] c2);
        int unsigned a00;
        int unsigned a01;
        int unsigned a10;
        int unsigned a11;
        a00 = k.k00;
        a01 = k.k01;
        a10 = k.k10;
        a11 = k.k11;
        c1 = '0;
        c2 = '0;
        for (int unsigned p = 0; p < 26; p++) begin
            for (int unsigned q = 0; q < 26; q++) begin
                if ((p * a00 + q * a10) % 26 == f && (p * a01 + q * a11) % 26 == s) begin
                    c1 = 5'(p);
                    c2 = 5'(q);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [4:0] random_key_entry();
        if ($urandom_range(9) == 0) return 5'($urandom_range(26, 31));
        return 5'($urandom_range(25));
    endfunction

    initial begin
        int          sent;
        int          phase;
        int          phase_sent;
        int          msg_len;
        int unsigned zx_pct;
        bit          noise;
        logic [4:0]  c1;
        logic [4:0]  c2;

        cur_key = '{k00: 5'd1, k01: 5'd0, k10: 5'd0, k11: 5'd1};
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        pair_ch.valid          <= 1'b0;
        pair_ch.cipher_first   <= '0;
        pair_ch.cipher_second  <= '0;
        pair_ch.last_pair      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset key is the identity, so these pairs decrypt to themselves
        // apart from out-of-range letters, which wrap mod 26.
        send_pair(5'd0, 5'd0, 1'b0);
        send_pair(5'd25, 5'd25, 1'b0);
        send_pair(5'd31, 5'd26, 1'b0);
        send_pair(LET_T, LET_E, 1'b0);
        send_pair(LET_Z, LET_X, 1'b1);
        send_pair(LET_T, LET_E, 1'b1);
        send_pair(5'd0, 5'd0, 1'b1);
        send_pair(LET_T, LET_T, 1'b0);
        send_pair(LET_E, LET_E, 1'b1);
        drain();
        set_key(5'd31, 5'd31, 5'd31, 5'd31);
        send_pair(5'd31, 5'd31, 1'b0);
        send_pair(5'd31, 5'd0, 1'b0);
        send_pair(5'd0, 5'd31, 1'b1);
        drain();
        set_key(5'd0, 5'd0, 5'd0, 5'd0);
        send_pair(5'd25, 5'd25, 1'b0);
        send_pair(5'd31, 5'd31, 1'b1);
        drain();
        set_key(5'd25, 5'd25, 5'd25, 5'd25);
        send_pair(5'd25, 5'd25, 1'b0);
        send_pair(5'd1, 5'd26, 1'b0);
        send_pair(5'd30, 5'd2, 1'b1);

        // A long stretch with no idling on either side. The first message has
        // a single Z and X and passes; the second is full of X and fails.
        drain();
        set_key(5'd1, 5'd0, 5'd0, 5'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_run(LET_T, LET_E, STREAM_PAIRS, 1'b0);
        send_run(LET_Z, LET_X, 1, 1'b1);
        send_run(LET_E, LET_X, STREAM_PAIRS, 1'b1);
        tx_idle_pct = 18;
        rx_idle_pct = 18;

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PAIRS) begin
            drain();
            if (phase == 0) begin
                set_key(5'd1, 5'd0, 5'd0, 5'd1);
            end else if (phase == 1) begin
                set_key(5'd3, 5'd2, 5'd5, 5'd7);
            end else begin
                set_key(random_key_entry(), random_key_entry(), random_key_entry(),
                        random_key_entry());
            end
            phase_sent = 0;
            while (phase_sent < PHASE_PAIRS) begin
                msg_len = ($urandom_range(19) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
                noise   = ($urandom_range(99) < 25);
                zx_pct  = $urandom_range(4);
                for (int i = 0; i < msg_len; i++) begin
                    if (noise || !find_cipher(cur_key, pick_plain(zx_pct), pick_plain(zx_pct),
                                              c1, c2)) begin
                        c1 = 5'($urandom_range(31));
                        c2 = 5'($urandom_range(31));
                    end
                    send_pair(c1, c2, i == msg_len - 1);
                    // Now and then hold the sender until every request is back.
                    if ($urandom_range(99) == 0) drain();
                end
                phase_sent += msg_len;
            end
            sent += phase_sent;
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/hdft_pkg.sv
src/hdft_if.sv
src/hdft_cfg.sv
src/hdft_mix.sv
src/hdft_freq.sv
src/hill_decrypt_with_frequency_test_unit.sv
verif/hdft_checker.sv
verif/hill_decrypt_with_frequency_test_unit_tb.sv
